/* src/assert_macros.svh */
// assertion helpers shared by the heap modules
// both expect clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define HPQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("heap queue assertion failed");

`define HPQ_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("heap queue assertion failed");

`endif

/* src/hpq_pkg.sv */
package hpq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // child index 2*i+2 of the last slot needs two bits above the slot index
  localparam int CH_W     = IDX_W + 2;
  localparam int ZONE_W   = 16;
  localparam int PRIO_W   = 31;
  localparam int OCC_W    = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef struct packed {
    logic [ZONE_W-1:0] zone;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_DISPATCH,
    CMD_LAST_RD,
    CMD_LAST_LD,
    CMD_UP_RD,
    CMD_UP_CMP,
    CMD_DN_RD,
    CMD_DN_CMP,
    CMD_LOAD_OUT
  } cmd_t;

  typedef struct packed {
    logic start_sift_up;
    logic start_sift_down;
    logic at_root;
    logic up_swap;
    logic at_leaf;
    logic dn_move;
  } status_t;

endpackage

/* src/hpq_req_if.sv */
interface hpq_req_if import hpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ZONE_W-1:0] zone_id;
  logic [PRIO_W-1:0] priority_req;

  modport source (output valid, operation, zone_id, priority_req, input ready);
  modport sink   (input valid, operation, zone_id, priority_req, output ready);
endinterface

/* src/hpq_rsp_if.sv */
interface hpq_rsp_if import hpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ZONE_W-1:0] top_zone;
  logic [PRIO_W-1:0] top_priority;
  logic              not_empty;
  logic [OCC_W-1:0]  occupancy;
  logic              refused;

  modport source (output valid, top_zone, top_priority, not_empty, occupancy, refused,
                  input ready);
  modport sink   (input valid, top_zone, top_priority, not_empty, occupancy, refused,
                  output ready);
endinterface

/* src/hpq_datapath.sv */
`include "assert_macros.svh"

module hpq_datapath import hpq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic              in_op,
  input  logic [ZONE_W-1:0] in_zone,
  input  logic [PRIO_W-1:0] in_prio,
  output logic [ZONE_W-1:0] out_zone,
  output logic [PRIO_W-1:0] out_prio,
  output logic              out_not_empty,
  output logic [OCC_W-1:0]  out_occupancy,
  output logic              out_refused
);

  entry_t mem [CAPACITY];

  logic             op;
  entry_t           item;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] pos;
  entry_t           hold;
  entry_t           root;
  logic             refused;
  entry_t           rd_a;
  entry_t           rd_b;

  logic             full;
  logic             empty;
  logic             bad_op;
  logic [IDX_W-1:0] parent;
  logic [CH_W-1:0]  left;
  logic [CH_W-1:0]  right;
  logic             left_in;
  logic             right_in;
  logic             pick_l;
  logic             pick_r;
  logic [PRIO_W-1:0] cur_prio;
  logic             dn_move;
  logic             up_swap;
  logic [IDX_W-1:0] child;
  entry_t           child_data;
  logic [IDX_W-1:0] rd_addr_a;
  logic [IDX_W-1:0] rd_addr_b;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign bad_op   = (op == OP_INSERT) ? full : empty;
  assign parent   = (pos - IDX_W'(1)) >> 1;
  assign left     = {1'b0, pos, 1'b1};
  assign right    = left + CH_W'(1);
  assign left_in  = (left < CH_W'(count));
  assign right_in = (right < CH_W'(count));

  // larger child, left wins ties, strict compare against the moving entry
  assign pick_l     = left_in && (rd_a.prio > hold.prio);
  assign cur_prio   = pick_l ? rd_a.prio : hold.prio;
  assign pick_r     = right_in && (rd_b.prio > cur_prio);
  assign dn_move    = pick_l || pick_r;
  assign child      = pick_r ? right[IDX_W-1:0] : left[IDX_W-1:0];
  assign child_data = pick_r ? rd_b : rd_a;
  assign up_swap    = (rd_a.prio < hold.prio);

  assign status.start_sift_up   = (op == OP_INSERT) && !full;
  assign status.start_sift_down = (op == OP_REMOVE) && (count > CNT_W'(1));
  assign status.at_root         = (pos == '0);
  assign status.up_swap         = up_swap;
  assign status.at_leaf         = !left_in;
  assign status.dn_move         = dn_move;

  always_comb begin
    case (cmd)
      CMD_LAST_RD: rd_addr_a = count[IDX_W-1:0];
      CMD_UP_RD:   rd_addr_a = parent;
      default:     rd_addr_a = left[IDX_W-1:0];
    endcase
  end
  assign rd_addr_b = right[IDX_W-1:0];

  // the moving entry stays in hold, one slot is written per level
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = hold;
    case (cmd)
      CMD_UP_RD: begin
        wr_en   = (pos == '0);
        wr_addr = '0;
      end
      CMD_UP_CMP: begin
        wr_en   = 1'b1;
        wr_data = up_swap ? rd_a : hold;
      end
      CMD_DN_RD: begin
        wr_en = !left_in;
      end
      CMD_DN_CMP: begin
        wr_en   = 1'b1;
        wr_data = dn_move ? child_data : hold;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd == CMD_DISPATCH) begin
      if (op == OP_INSERT && !full) begin
        count <= count + CNT_W'(1);
      end else if (op == OP_REMOVE && !empty) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_addr == '0) begin
      root <= wr_data;
    end
    case (cmd)
      CMD_ACCEPT: begin
        op   <= in_op;
        item <= '{zone: in_zone, prio: in_prio};
      end
      CMD_DISPATCH: begin
        refused <= bad_op;
        pos     <= count[IDX_W-1:0];
        hold    <= item;
      end
      CMD_LAST_LD: begin
        hold <= rd_a;
        pos  <= '0;
      end
      CMD_UP_CMP: begin
        if (up_swap) begin
          pos <= parent;
        end
      end
      CMD_DN_CMP: begin
        if (dn_move) begin
          pos <= child;
        end
      end
      CMD_LOAD_OUT: begin
        out_zone      <= empty ? '0 : root.zone;
        out_prio      <= empty ? '0 : root.prio;
        out_not_empty <= !empty;
        out_occupancy <= OCC_W'(count);
        out_refused   <= refused;
      end
      default: begin
      end
    endcase
  end

  `HPQ_ASSERT(a_count_cap, count <= CNT_W'(CAPACITY))
  `HPQ_ASSERT(a_wr_in_heap, wr_en |-> (CNT_W'(wr_addr) < count))
  `HPQ_ASSERT_NEXT(a_refuse_only_bad, cmd == CMD_DISPATCH && !bad_op, !refused)

endmodule

/* src/hpq_ctrl.sv */
`include "assert_macros.svh"

module hpq_ctrl import hpq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LAST_RD,
    S_LAST_LD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd        = CMD_ACCEPT;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd = CMD_DISPATCH;
        if (status.start_sift_up) begin
          state_next = S_UP_RD;
        end else if (status.start_sift_down) begin
          state_next = S_LAST_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_LAST_RD: begin
        cmd        = CMD_LAST_RD;
        state_next = S_LAST_LD;
      end
      S_LAST_LD: begin
        cmd        = CMD_LAST_LD;
        state_next = S_DN_RD;
      end
      S_UP_RD: begin
        cmd        = CMD_UP_RD;
        state_next = status.at_root ? S_DONE : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd        = CMD_UP_CMP;
        state_next = status.up_swap ? S_UP_RD : S_DONE;
      end
      S_DN_RD: begin
        cmd        = CMD_DN_RD;
        state_next = status.at_leaf ? S_DONE : S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd        = CMD_DN_CMP;
        state_next = status.dn_move ? S_DN_RD : S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd        = CMD_LOAD_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd == CMD_LOAD_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `HPQ_ASSERT_NEXT(a_done_drains, state == S_DONE && !out_valid, state == S_IDLE && out_valid)
  `HPQ_ASSERT(a_load_when_free, (cmd == CMD_LOAD_OUT) |-> out_free)
  `HPQ_ASSERT(a_last_order, (state == S_LAST_LD) |-> ($past(state) == S_LAST_RD))

endmodule

/* src/max_heap_priority_queue.sv */
// channel | interface   | fields
// req     | hpq_req_if  | operation, zone_id, priority_req
// rsp     | hpq_rsp_if  | top_zone, top_priority, not_empty, occupancy, refused
//
// one item in flight; an item runs from idle through dispatch, the sift and the output load,
// each level of the 64-slot heap taking a read state and a compare state
// req is taken while a finished rsp beat still waits in the output register
// rst is synchronous and empties the heap; slot contents are not cleared
// a stalled rsp holds the block in its final state until the beat is taken
module max_heap_priority_queue import hpq_pkg::*; (
  input logic       clk,
  input logic       rst,
  hpq_req_if.sink   req,
  hpq_rsp_if.source rsp
);

  cmd_t    cmd;
  status_t status;

  hpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  hpq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_op         (req.operation),
    .in_zone       (req.zone_id),
    .in_prio       (req.priority_req),
    .out_zone      (rsp.top_zone),
    .out_prio      (rsp.top_priority),
    .out_not_empty (rsp.not_empty),
    .out_occupancy (rsp.occupancy),
    .out_refused   (rsp.refused)
  );

endmodule

/* sim/testbench.sv */
module testbench import hpq_pkg::*; ();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_OPS  = 1750;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 24;

  typedef struct packed {
    logic              operation;
    logic [ZONE_W-1:0] zone_id;
    logic [PRIO_W-1:0] priority_req;
  } heap_op_t;

  typedef struct packed {
    logic [ZONE_W-1:0] top_zone;
    logic [PRIO_W-1:0] top_priority;
    logic              not_empty;
    logic [OCC_W-1:0]  occupancy;
    logic              refused;
  } heap_top_t;

  logic clk;
  logic rst;

  hpq_req_if req_ch ();
  hpq_rsp_if rsp_ch ();

  max_heap_priority_queue dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  heap_op_t  pending_ops[$];
  heap_top_t expected_tops[$];

  // shadow copy of the heap store
  entry_t shadow_heap [CAPACITY];
  int     shadow_count = 0;

  int gen_count = 0;
  int inserts = 0, removes = 0, full_refusals = 0, empty_refusals = 0;
  int peak_occupancy = 0;
  int rsp_beats = 0;
  int mismatches = 0;
  int cycle_count = 0;

  bit       req_taken = 1'b0;
  bit       offering = 1'b0;
  int       gap_left = 0, burst_left = 0;
  heap_op_t drive_item;

  int stall_left = 0, rcv_burst_left = 0, hold_left = 0, holds_done = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) pick_gap = 0;
    else if (r < 90) pick_gap = $urandom_range(1, 3);
    else pick_gap = $urandom_range(10, 60);
  endfunction

  function automatic logic [PRIO_W-1:0] pick_prio();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) pick_prio = '0;
    else if (r == 1) pick_prio = '1;
    else if (r < 5) pick_prio = PRIO_W'($urandom_range(0, 15));
    else pick_prio = PRIO_W'($urandom);
  endfunction

  // applies one operation to the shadow heap and returns the expected beat: the root it leaves, occupancy and refusal
  function automatic heap_top_t predict_top(heap_op_t op);
    heap_top_t res;
    entry_t    tmp;
    int        pos, parent, best, left, right;
    logic      done;
    res = '0;
    if (op.operation == OP_INSERT) begin
      inserts++;
      if (shadow_count >= CAPACITY) begin
        res.refused = 1'b1;
        full_refusals++;
      end else begin
        shadow_heap[shadow_count].zone = op.zone_id;
        shadow_heap[shadow_count].prio = op.priority_req;
        pos = shadow_count;
        shadow_count++;
        done = 1'b0;
        while (pos > 0 && !done) begin
          parent = (pos - 1) / 2;
          if (shadow_heap[parent].prio < shadow_heap[pos].prio) begin
            tmp = shadow_heap[parent];
            shadow_heap[parent] = shadow_heap[pos];
            shadow_heap[pos] = tmp;
            pos = parent;
          end else begin
            done = 1'b1;
          end
        end
      end
    end else begin
      removes++;
      if (shadow_count == 0) begin
        res.refused = 1'b1;
        empty_refusals++;
      end else begin
        shadow_count--;
        shadow_heap[0] = shadow_heap[shadow_count];
        pos = 0;
        done = 1'b0;
        while (pos < shadow_count && !done) begin
          best  = pos;
          left  = 2 * pos + 1;
          right = 2 * pos + 2;
          // strict compares, so the left child wins a tie
          if (left < shadow_count && shadow_heap[left].prio > shadow_heap[best].prio)
            best = left;
          if (right < shadow_count && shadow_heap[right].prio > shadow_heap[best].prio)
            best = right;
          if (best == pos) begin
            done = 1'b1;
          end else begin
            tmp = shadow_heap[pos];
            shadow_heap[pos] = shadow_heap[best];
            shadow_heap[best] = tmp;
            pos = best;
          end
        end
      end
    end
    if (shadow_count > 0) begin
      res.top_zone     = shadow_heap[0].zone;
      res.top_priority = shadow_heap[0].prio;
      res.not_empty    = 1'b1;
    end
    res.occupancy = OCC_W'(shadow_count);
    if (shadow_count > peak_occupancy) peak_occupancy = shadow_count;
    predict_top = res;
  endfunction

  task automatic queue_op(logic op, logic [ZONE_W-1:0] zone, logic [PRIO_W-1:0] prio);
    heap_op_t item;
    item.operation    = op;
    item.zone_id      = zone;
    item.priority_req = prio;
    pending_ops.insert(pending_ops.size(), item);
    if (op == OP_INSERT && gen_count < CAPACITY) gen_count++;
    else if (op == OP_REMOVE && gen_count > 0) gen_count--;
  endtask

  task automatic queue_random_remove();
    queue_op(OP_REMOVE, ZONE_W'($urandom), PRIO_W'($urandom));
  endtask

  task automatic queue_random_insert();
    queue_op(OP_INSERT, ZONE_W'($urandom), pick_prio());
  endtask

  // driver: new beat offered at the falling edge once the previous one is taken
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      offering = 1'b0;
    end else if (!offering || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        offering = 1'b0;
        req_ch.valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        drive_item = pending_ops.pop_front();
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= drive_item.operation;
        req_ch.zone_id      <= drive_item.zone_id;
        req_ch.priority_req <= drive_item.priority_req;
        offering = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          gap_left = pick_gap();
          if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 60);
        end
      end else begin
        offering = 1'b0;
        req_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus two long hold-offs so the block backs up
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (holds_done < 2 && rsp_beats >= ((holds_done == 0) ? 400 : 1300)) begin
      hold_left = LONG_HOLD - 1;
      holds_done++;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (rcv_burst_left > 0) rcv_burst_left--;
      else if ($urandom_range(0, 5) == 0) stall_left = pick_gap();
      else if ($urandom_range(0, 199) == 0) rcv_burst_left = $urandom_range(50, 200);
    end
  end

  // monitor: check the response beat first, then predict the accepted request
  always @(posedge clk) begin
    heap_top_t got, want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      rsp_beats++;
      got.top_zone     = rsp_ch.top_zone;
      got.top_priority = rsp_ch.top_priority;
      got.not_empty    = rsp_ch.not_empty;
      got.occupancy    = rsp_ch.occupancy;
      got.refused      = rsp_ch.refused;
      if (expected_tops.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("error: unexpected response beat zone=%h prio=%h ne=%b occ=%0d ref=%b",
                   got.top_zone, got.top_priority, got.not_empty, got.occupancy, got.refused);
      end else begin
        want = expected_tops.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"error: beat %0d expected zone=%h prio=%h ne=%b occ=%0d ref=%b,",
                      " got zone=%h prio=%h ne=%b occ=%0d ref=%b"}, rsp_beats,
                     want.top_zone, want.top_priority, want.not_empty, want.occupancy,
                     want.refused, got.top_zone, got.top_priority, got.not_empty,
                     got.occupancy, got.refused);
        end
      end
    end
    if (!rst && req_ch.valid && req_ch.ready) begin
      req_taken = 1'b1;
      expected_tops.insert(expected_tops.size(),
                           predict_top('{req_ch.operation, req_ch.zone_id,
                                         req_ch.priority_req}));
    end else begin
      req_taken = 1'b0;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int seg, len, ins_pct, k;
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.operation    = OP_INSERT;
    req_ch.zone_id      = '0;
    req_ch.priority_req = '0;
    rsp_ch.ready        = 1'b0;

    // directed: empty remove, extremes, equal keys, drain past empty
    queue_op(OP_REMOVE, '1, '1);
    queue_op(OP_INSERT, 16'h0000, '0);
    queue_op(OP_INSERT, 16'hffff, '1);
    queue_op(OP_INSERT, 16'h1234, '1);
    queue_op(OP_INSERT, 16'haaaa, 31'h7fff_fffe);
    queue_op(OP_INSERT, 16'h5555, 31'h2aaa_aaaa);
    queue_op(OP_INSERT, 16'h0f0f, 31'h5555_5555);
    repeat (7) queue_random_remove();
    // two equal children under a smaller moved-up entry
    queue_op(OP_INSERT, 16'h000a, 31'd50);
    queue_op(OP_INSERT, 16'h000b, 31'd30);
    queue_op(OP_INSERT, 16'h000c, 31'd30);
    queue_op(OP_INSERT, 16'h000d, 31'd10);
    repeat (4) queue_random_remove();

    // random: fill and drain runs reach full and empty, mixed runs in between
    k = 0;
    while (k < RANDOM_OPS) begin
      seg = (k == 0) ? 0 : $urandom_range(0, 9);
      if (seg < 2) begin
        while (gen_count < CAPACITY) begin
          queue_random_insert();
          k++;
        end
        repeat ($urandom_range(1, 3)) begin
          queue_random_insert();
          k++;
        end
      end else if (seg < 4) begin
        while (gen_count > 0) begin
          queue_random_remove();
          k++;
        end
        repeat ($urandom_range(1, 2)) begin
          queue_random_remove();
          k++;
        end
      end else begin
        len = $urandom_range(10, 80);
        ins_pct = 30 + 20 * $urandom_range(0, 2);
        repeat (len) begin
          if ($urandom_range(0, 99) < ins_pct) queue_random_insert();
          else queue_random_remove();
          k++;
        end
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || offering) @(posedge clk);
    while (expected_tops.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d inserts (%0d refused on full) and %0d removes (%0d refused on empty)",
             inserts, full_refusals, removes, empty_refusals);
    $display("peak occupancy %0d of %0d, %0d response beats, %0d long receiver hold-offs",
             peak_occupancy, CAPACITY, rsp_beats, holds_done);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
